FILE: src/mnac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnac_pkg: shared types and constants
// Group size, conversion constants, register indexes and the control
// structs passed between the core and the median unit.
// ----------------------------------------------------------------------------
package mnac_pkg;

  localparam int unsigned SAMPLES_PER_GROUP = 9;
  localparam int unsigned CNT_W = $clog2(SAMPLES_PER_GROUP + 1);
  localparam int unsigned IDX_W = $clog2(SAMPLES_PER_GROUP);
  localparam logic [CNT_W-1:0] MED_RANK = CNT_W'(SAMPLES_PER_GROUP / 2);

  localparam int unsigned CH_W   = 8;
  localparam int unsigned SMP_W  = 8;
  localparam int unsigned CV_W   = 10;
  localparam int unsigned PROD_W = 17;
  localparam int unsigned RAW_CV_W = PROD_W - SMP_W;

  // ceil(m * 330 / 256) = (m * 330 + 255) >> 8
  localparam logic [PROD_W-1:0] SCALE_MUL = PROD_W'(330);
  localparam logic [PROD_W-1:0] ROUND_ADD = PROD_W'(255);

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOARD_KIND = 8'd0,
    REG_LEFT_ID    = 8'd1,
    REG_RIGHT_ID   = 8'd2,
    REG_POWER_ID   = 8'd3
  } cfg_reg_e;

  typedef enum logic {
    STATUS_OK      = 1'b0,
    STATUS_UNKNOWN = 1'b1
  } status_e;

  typedef enum logic {
    MODE_MEDIAN = 1'b0,
    MODE_DIRECT = 1'b1
  } mode_e;

  typedef struct packed {
    logic             push;
    logic [SMP_W-1:0] data;
    logic             start;
  } med_ctrl_t;

  typedef struct packed {
    logic             done;
    logic [SMP_W-1:0] median;
  } med_stat_t;

endpackage

FILE: src/mnac_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnac_in_if: sample request channel
// Valid/ready channel carrying a channel number and a raw sample.
// ----------------------------------------------------------------------------
interface mnac_in_if import mnac_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CH_W-1:0]  channel;
  logic [SMP_W-1:0] sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface

FILE: src/mnac_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnac_out_if: result channel
// Valid/ready channel carrying status and voltage in hundredths of a volt.
// ----------------------------------------------------------------------------
interface mnac_out_if import mnac_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            status;
  logic [CV_W-1:0] centivolts;

  modport source (output valid, output status, output centivolts, input ready);
  modport sink   (input valid, input status, input centivolts, output ready);
endinterface

FILE: src/mnac_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnac_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface mnac_cfg_if import mnac_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/median_nine_adc_to_centivolts_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_nine_adc_to_centivolts_core: converter front end
// Median-of-nine (or direct) conversion of 8-bit samples to centivolts.
// ----------------------------------------------------------------------------
// One request at a time. An unknown channel goes through S_EMIT, a direct
// sample through S_CONV and S_EMIT, and a request that only joins a group
// stays in S_IDLE. The request that completes a group starts the median unit,
// which tests each stored sample as a candidate with one comparator: load, N
// compares and a check per candidate, for up to N candidates. The median is
// then handed back, converted in S_CONV and emitted in S_EMIT. The result sits
// in an output register; the next request is taken once the previous result
// has been moved there. Config writes are always accepted, one per cycle.
module median_nine_adc_to_centivolts_core
  import mnac_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  mnac_in_if.sink    req_i,
  mnac_out_if.source rsp_o,
  mnac_cfg_if.sink   cfg_i
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MED  = 4'b0010,
    S_CONV = 4'b0100,
    S_EMIT = 4'b1000
  } core_state_e;

  core_state_e state_q, state_d;

  // configuration registers
  mode_e           mode_q;
  logic [CH_W-1:0] left_id_q, right_id_q, power_id_q;

  // group tracking
  logic [CNT_W-1:0] count_q, count_d;
  logic [CH_W-1:0]  group_ch_q, group_ch_d;

  // request working registers
  logic [SMP_W-1:0]  raw_q, raw_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic              power_q, power_d;
  logic              err_q, err_d;

  // result register
  logic            out_valid_q, out_valid_d;
  logic            out_status_q, out_status_d;
  logic [CV_W-1:0] out_cv_q, out_cv_d;

  med_ctrl_t med_ctrl;
  med_stat_t med_stat;

  logic             req_fire;
  logic             known;
  logic [CNT_W-1:0] cnt_base;
  logic [CNT_W-1:0] cnt_next;
  logic             out_free;
  logic [RAW_CV_W-1:0] cv_raw;
  logic [CV_W-1:0]     cv_final;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;
  assign out_free    = !out_valid_q || rsp_o.ready;

  assign known = (req_i.channel == left_id_q) || (req_i.channel == right_id_q)
              || (req_i.channel == power_id_q);

  // a change of channel drops a partial group
  always_comb begin
    cnt_base = count_q;
    if ((count_q != '0) && (req_i.channel != group_ch_q)) begin
      cnt_base = '0;
    end
    if (cnt_base >= CNT_W'(SAMPLES_PER_GROUP)) begin
      cnt_base = '0;
    end
    cnt_next = cnt_base + CNT_W'(1);
  end

  // ceil(m*330/256), tripled on the supply channel
  assign cv_raw   = prod_q[PROD_W-1:SMP_W];
  assign cv_final = power_q ? ({1'b0, cv_raw} + {cv_raw, 1'b0}) : {1'b0, cv_raw};

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    group_ch_d   = group_ch_q;
    raw_d        = raw_q;
    prod_d       = prod_q;
    power_d      = power_q;
    err_d        = err_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_cv_d     = out_cv_q;
    med_ctrl     = '{push: 1'b0, data: req_i.sample, start: 1'b0};
    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          power_d = (req_i.channel == power_id_q);
          raw_d   = req_i.sample;
          if (!known) begin
            err_d   = 1'b1;
            state_d = S_EMIT;
          end else if (mode_q == MODE_DIRECT) begin
            err_d   = 1'b0;
            state_d = S_CONV;
          end else begin
            err_d         = 1'b0;
            group_ch_d    = req_i.channel;
            med_ctrl.push = 1'b1;
            if (cnt_next == CNT_W'(SAMPLES_PER_GROUP)) begin
              count_d        = '0;
              med_ctrl.start = 1'b1;
              state_d        = S_MED;
            end else begin
              count_d = cnt_next;
            end
          end
        end
      end
      S_MED: begin
        if (med_stat.done) begin
          raw_d   = med_stat.median;
          state_d = S_CONV;
        end
      end
      S_CONV: begin
        prod_d  = PROD_W'(raw_q) * SCALE_MUL + ROUND_ADD;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (err_q) begin
            out_status_d = STATUS_UNKNOWN;
            out_cv_d     = '0;
          end else begin
            out_status_d = STATUS_OK;
            out_cv_d     = cv_final;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      group_ch_q  <= '0;
      out_valid_q <= 1'b0;
      mode_q      <= MODE_MEDIAN;
      left_id_q   <= CH_W'(0);
      right_id_q  <= CH_W'(1);
      power_id_q  <= CH_W'(2);
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      group_ch_q  <= group_ch_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        case (cfg_i.index)
          REG_BOARD_KIND: mode_q     <= mode_e'(cfg_i.data[0]);
          REG_LEFT_ID:    left_id_q  <= cfg_i.data;
          REG_RIGHT_ID:   right_id_q <= cfg_i.data;
          REG_POWER_ID:   power_id_q <= cfg_i.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    raw_q        <= raw_d;
    prod_q       <= prod_d;
    power_q      <= power_d;
    err_q        <= err_d;
    out_status_q <= out_status_d;
    out_cv_q     <= out_cv_d;
  end

  mnac_median u_median (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (med_ctrl),
    .stat_o (med_stat)
  );

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.centivolts = out_cv_q;

endmodule

FILE: src/mnac_median.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnac_median: rank-count median unit
// Samples sit in a rotating ring; one comparator counts, for each
// candidate, how many samples are below and equal to it.
// ----------------------------------------------------------------------------
module mnac_median
  import mnac_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  med_ctrl_t ctrl_i,
  output med_stat_t stat_o
);

  typedef enum logic [3:0] {
    M_IDLE  = 4'b0001,
    M_LOAD  = 4'b0010,
    M_SCAN  = 4'b0100,
    M_CHECK = 4'b1000
  } med_state_e;

  med_state_e       state_q, state_d;
  logic [SMP_W-1:0] ring_q [SAMPLES_PER_GROUP];
  logic [SMP_W-1:0] cand_q, cand_d;
  logic [SMP_W-1:0] median_q, median_d;
  logic [CNT_W-1:0] lt_q, lt_d, eq_q, eq_d;
  logic [IDX_W-1:0] pos_q, pos_d;
  logic             done_q, done_d;
  logic             shift;
  logic [SMP_W-1:0] shift_in;
  logic [CNT_W:0]   upper;
  logic             hit;

  assign upper = {1'b0, lt_q} + {1'b0, eq_q};
  assign hit   = (lt_q <= MED_RANK) && ({1'b0, MED_RANK} < upper);

  // ring shift: push loads the tail, rotate feeds the head back round
  always_ff @(posedge clk_i) begin
    if (shift) begin
      for (int i = 0; i < SAMPLES_PER_GROUP - 1; i++) begin
        ring_q[i] <= ring_q[i+1];
      end
      ring_q[SAMPLES_PER_GROUP-1] <= shift_in;
    end
  end

  always_comb begin
    state_d  = state_q;
    cand_d   = cand_q;
    median_d = median_q;
    lt_d     = lt_q;
    eq_d     = eq_q;
    pos_d    = pos_q;
    done_d   = 1'b0;
    shift    = 1'b0;
    shift_in = ring_q[0];
    case (state_q)
      M_IDLE: begin
        if (ctrl_i.push) begin
          shift    = 1'b1;
          shift_in = ctrl_i.data;
        end
        if (ctrl_i.start) begin
          state_d = M_LOAD;
        end
      end
      M_LOAD: begin
        cand_d  = ring_q[0];
        lt_d    = '0;
        eq_d    = '0;
        pos_d   = '0;
        state_d = M_SCAN;
      end
      M_SCAN: begin
        shift = 1'b1;
        if (ring_q[0] < cand_q) begin
          lt_d = lt_q + CNT_W'(1);
        end
        if (ring_q[0] == cand_q) begin
          eq_d = eq_q + CNT_W'(1);
        end
        pos_d = pos_q + IDX_W'(1);
        if (pos_q == IDX_W'(SAMPLES_PER_GROUP - 1)) begin
          state_d = M_CHECK;
        end
      end
      M_CHECK: begin
        if (hit) begin
          median_d = cand_q;
          done_d   = 1'b1;
          state_d  = M_IDLE;
        end else begin
          // step to the next candidate
          shift   = 1'b1;
          state_d = M_LOAD;
        end
      end
      default: state_d = M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q   <= cand_d;
    median_q <= median_d;
    lt_q     <= lt_d;
    eq_q     <= eq_d;
    pos_q    <= pos_d;
  end

  assign stat_o.done   = done_q;
  assign stat_o.median = median_q;

endmodule
